// ===== rtl/core/nsqrt_pkg.sv =====
// Shared types, opcodes and microcode for the Newton-Raphson square root.
// No dependencies; used by nsqrt_useq, nsqrt_dp and newton_square_root.
package nsqrt_pkg;

    typedef logic [2:0] op_t;
    typedef logic [2:0] cond_t;
    typedef logic [2:0] pc_t;

    // datapath operations
    localparam op_t OP_LOAD   = 3'd0;
    localparam op_t OP_ZCHK   = 3'd1;
    localparam op_t OP_BLEN   = 3'd2;
    localparam op_t OP_XINIT  = 3'd3;
    localparam op_t OP_DINIT  = 3'd4;
    localparam op_t OP_DSTEP  = 3'd5;
    localparam op_t OP_UPDATE = 3'd6;
    localparam op_t OP_OUT    = 3'd7;

    // jump conditions
    localparam cond_t COND_NEVER  = 3'd0;
    localparam cond_t COND_ALWAYS = 3'd1;
    localparam cond_t COND_IDLE   = 3'd2;
    localparam cond_t COND_NZERO  = 3'd3;
    localparam cond_t COND_SHNZ   = 3'd4;
    localparam cond_t COND_DMORE  = 3'd5;
    localparam cond_t COND_YLESS  = 3'd6;

    // step addresses
    localparam pc_t PC_IDLE   = 3'd0;
    localparam pc_t PC_ZCHK   = 3'd1;
    localparam pc_t PC_BLEN   = 3'd2;
    localparam pc_t PC_XINIT  = 3'd3;
    localparam pc_t PC_DINIT  = 3'd4;
    localparam pc_t PC_DSTEP  = 3'd5;
    localparam pc_t PC_UPDATE = 3'd6;
    localparam pc_t PC_OUT    = 3'd7;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        logic n_zero;
        logic sh_nz;
        logic div_more;
        logic y_less;
    } dp_status_t;

    // control store: taken jump goes to target, otherwise pc + 1
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        case (pc)
            PC_IDLE:   w = '{op: OP_LOAD,   cond: COND_IDLE,   target: PC_IDLE};
            PC_ZCHK:   w = '{op: OP_ZCHK,   cond: COND_NZERO,  target: PC_OUT};
            PC_BLEN:   w = '{op: OP_BLEN,   cond: COND_SHNZ,   target: PC_BLEN};
            PC_XINIT:  w = '{op: OP_XINIT,  cond: COND_NEVER,  target: PC_IDLE};
            PC_DINIT:  w = '{op: OP_DINIT,  cond: COND_NEVER,  target: PC_IDLE};
            PC_DSTEP:  w = '{op: OP_DSTEP,  cond: COND_DMORE,  target: PC_DSTEP};
            PC_UPDATE: w = '{op: OP_UPDATE, cond: COND_YLESS,  target: PC_DINIT};
            PC_OUT:    w = '{op: OP_OUT,    cond: COND_ALWAYS, target: PC_IDLE};
            default:   w = '{op: OP_LOAD,   cond: COND_ALWAYS, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/nsqrt_useq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on nsqrt_pkg.
module nsqrt_useq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  nsqrt_pkg::dp_status_t  status,
    output nsqrt_pkg::op_t         op,
    output logic                   busy,
    output logic                   done
);
    import nsqrt_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   jump;

    assign uw = ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            COND_NEVER:  jump = 1'b0;
            COND_ALWAYS: jump = 1'b1;
            COND_IDLE:   jump = !start;
            COND_NZERO:  jump = status.n_zero;
            COND_SHNZ:   jump = status.sh_nz;
            COND_DMORE:  jump = status.div_more;
            COND_YLESS:  jump = status.y_less;
            default:     jump = 1'b0;
        endcase
        pc_next = jump ? uw.target : pc_t'(pc_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign op   = uw.op;
    assign busy = (pc_reg != PC_IDLE);
    assign done = (uw.op == OP_OUT);

endmodule

// ===== rtl/core/nsqrt_dp.sv =====
// Datapath: radicand, bit-length counter, serial restoring divider and
// Newton update of the estimate. Driven one opcode per cycle. Depends on nsqrt_pkg.
module nsqrt_dp #(
    parameter int RADICAND_BITS = 48,
    parameter int FRACTION_BITS = 16,
    parameter int ROOT_BITS     = (RADICAND_BITS + 1) / 2 + FRACTION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nsqrt_pkg::op_t        op,
    input  logic [RADICAND_BITS-1:0] radicand,
    output nsqrt_pkg::dp_status_t status,
    output logic [ROOT_BITS-1:0]  root
);
    import nsqrt_pkg::*;

    localparam int MW = RADICAND_BITS + 2 * FRACTION_BITS;
    localparam int XW = ROOT_BITS + 1;
    localparam int LW = $clog2(RADICAND_BITS + 1);
    localparam int BW = $clog2(MW + 2) + 1;
    localparam int CW = (MW > 1) ? $clog2(MW) : 1;
    localparam logic [XW-1:0] X_SAT = XW'({64{1'b1}});

    logic [RADICAND_BITS-1:0] n_reg, n_next;
    logic [RADICAND_BITS-1:0] sh_reg, sh_next;
    logic [LW-1:0]            len_reg, len_next;
    logic [XW-1:0]            x_reg, x_next;
    logic [3:0]               count_reg, count_next;
    logic [MW-1:0]            dvd_reg, dvd_next;
    logic [MW-1:0]            q_reg, q_next;
    logic [XW-1:0]            rem_reg, rem_next;
    logic [CW-1:0]            cnt_reg, cnt_next;

    logic [BW-1:0]            blen;
    logic [BW-1:0]            half;
    logic [XW-1:0]            x_start;
    logic [XW:0]              trial;
    logic                     fits;
    logic [MW:0]              sum;
    logic [MW-1:0]            y;

    always_comb
    begin
        blen    = BW'(len_reg) + BW'(2 * FRACTION_BITS);
        half    = BW'((blen + BW'(1)) >> 1);
        x_start = (half >= BW'(64)) ? X_SAT : (XW'(1) << half);
        trial   = {rem_reg, dvd_reg[MW-1]};
        fits    = (trial >= {1'b0, x_reg});
        sum     = {1'b0, q_reg} + (MW+1)'(x_reg);
        y       = sum[MW:1];
    end

    assign status.n_zero   = (n_reg == '0);
    assign status.sh_nz    = (sh_reg != '0);
    assign status.div_more = (cnt_reg != '0);
    assign status.y_less   = (y < MW'(x_reg));

    always_comb
    begin
        n_next     = n_reg;
        sh_next    = sh_reg;
        len_next   = len_reg;
        x_next     = x_reg;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (op)
            OP_LOAD:
            begin
                n_next = radicand;
            end
            OP_ZCHK:
            begin
                sh_next    = n_reg;
                len_next   = '0;
                x_next     = '0;
                count_next = '0;
            end
            OP_BLEN:
            begin
                if (sh_reg != '0)
                begin
                    sh_next  = sh_reg >> 1;
                    len_next = LW'(len_reg + LW'(1));
                end
            end
            OP_XINIT:
            begin
                x_next = x_start;
            end
            OP_DINIT:
            begin
                dvd_next = MW'({n_reg, {(2 * FRACTION_BITS + 1){1'b0}}} >> 1);
                q_next   = '0;
                rem_next = '0;
                cnt_next = CW'(MW - 1);
            end
            OP_DSTEP:
            begin
                dvd_next = dvd_reg << 1;
                q_next   = {q_reg[MW-2:0], fits};
                rem_next = fits ? XW'(trial - {1'b0, x_reg}) : XW'(trial);
                cnt_next = CW'(cnt_reg - CW'(1));
            end
            OP_UPDATE:
            begin
                if (count_reg != 4'hF)
                begin
                    count_next = count_reg + 4'd1;
                end
                if (y < MW'(x_reg))
                begin
                    x_next = XW'(y);
                end
            end
            OP_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            x_reg     <= x_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        sh_reg  <= sh_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign root = x_reg[ROOT_BITS-1:0];

endmodule

// ===== rtl/core/newton_square_root.sv =====
// Top level of the Newton-Raphson fixed-point square root.
// Depends on nsqrt_pkg, nsqrt_useq and nsqrt_dp.
//
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------
//   request  | start, busy         | radicand [RADICAND_BITS-1:0]
//   result   | done (1-cycle beat) | root [ROOT_BITS-1:0]
//
// A beat is taken when start is high and busy is low. A zero radicand
// goes from the zero check straight to output. Otherwise the run finds
// the bit length, seeds the estimate, then does Newton steps (division
// by the one-bit-per-cycle restoring divider, then the update) while the
// estimate falls, then output. Reset clears the sequencer to idle.
// The result beat cannot be stalled; busy drops the cycle after done.
module newton_square_root #(
    parameter int RADICAND_BITS = 48,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [RADICAND_BITS-1:0] radicand,
    output logic                     done,
    output logic [(RADICAND_BITS+1)/2+FRACTION_BITS-1:0] root
);
    import nsqrt_pkg::*;

    localparam int ROOT_BITS = (RADICAND_BITS + 1) / 2 + FRACTION_BITS;

    op_t        op;
    dp_status_t status;

    nsqrt_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy),
        .done   (done)
    );

    nsqrt_dp #(
        .RADICAND_BITS (RADICAND_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .ROOT_BITS     (ROOT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .radicand (radicand),
        .status   (status),
        .root     (root)
    );

endmodule

// ===== tb/sv/newton_square_root_checker.sv =====
// Checker for newton_square_root: watches the request and result beats,
// predicts each root by integer Newton iteration and compares in order.
// No dependencies; instantiated by tb_top beside the block.
module newton_square_root_checker #(
    parameter int RADICAND_BITS = 48,
    parameter int FRACTION_BITS = 16,
    parameter int ROOT_BITS     = (RADICAND_BITS + 1) / 2 + FRACTION_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [RADICAND_BITS-1:0] radicand,
    input  logic                     done,
    input  logic [ROOT_BITS-1:0]     root,
    output int                       outstanding,
    output int                       fail_count
);

    localparam int ESTIMATE_BITS = 41;
    localparam int COUNT_MAX     = 15;

    typedef struct packed {
        logic [RADICAND_BITS-1:0] radicand;
        logic [ROOT_BITS-1:0]     root;
    } root_entry_t;

    root_entry_t              pending_roots[$];
    logic [ESTIMATE_BITS-1:0] last_estimate;
    logic [3:0]               last_steps;

    initial
    begin
        outstanding   = 0;
        fail_count    = 0;
        last_estimate = '0;
        last_steps    = '0;
    end

    // floor(sqrt(n * 2^(2*FRACTION_BITS))), Newton from a power of two above the root
    function automatic logic [ROOT_BITS-1:0] predict_root(input logic [RADICAND_BITS-1:0] n);
        logic [127:0] scaled;
        logic [127:0] quot;
        logic [127:0] next_est;
        logic [63:0]  est;
        int           bits;
        int           half;
        int           steps;
        bit           settled;
        scaled = {{(128 - RADICAND_BITS){1'b0}}, n} << (2 * FRACTION_BITS);
        if (scaled == '0)
        begin
            last_estimate = '0;
            last_steps    = '0;
            return '0;
        end
        bits = 0;
        for (int i = 0; i < 128; i++)
            if (scaled[i])
                bits = i + 1;
        half    = (bits + 1) / 2;
        est     = (half >= 64) ? {64{1'b1}} : (64'd1 << half);
        steps   = 0;
        settled = 1'b0;
        while (!settled)
        begin
            quot     = scaled / {64'd0, est};
            next_est = (quot + {64'd0, est}) >> 1;
            if (steps < COUNT_MAX)
                steps++;
            if (next_est >= {64'd0, est})
                settled = 1'b1;
            else
                est = next_est[63:0];
        end
        last_estimate = est[ESTIMATE_BITS-1:0];
        last_steps    = steps[3:0];
        return est[ROOT_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        root_entry_t entry;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_roots.size() == 0)
                    report_mismatch($sformatf("result beat root=%h with nothing pending", root));
                else
                begin
                    entry = pending_roots.pop_front();
                    if (root !== entry.root)
                        report_mismatch($sformatf("radicand=%h root=%h want %h",
                                                  entry.radicand, root, entry.root));
                end
            end
            if (start && !busy)
            begin
                entry.radicand = radicand;
                entry.root     = predict_root(radicand);
                pending_roots.push_back(entry);
            end
            outstanding = pending_roots.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for newton_square_root: clock, reset, radicand stimulus and verdict.
// Depends on newton_square_root and newton_square_root_checker.
module tb_top;

    localparam int RADICAND_BITS = 48;
    localparam int FRACTION_BITS = 16;
    localparam int ROOT_BITS     = (RADICAND_BITS + 1) / 2 + FRACTION_BITS;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int DIRECTED_N    = 20;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [RADICAND_BITS-1:0] radicand;
    logic                     done;
    logic [ROOT_BITS-1:0]     root;
    int                       outstanding;
    int                       fail_count;

    logic [RADICAND_BITS-1:0] directed [DIRECTED_N] = '{
        48'h0, 48'h1, 48'h2, 48'h3, 48'h4, 48'h5, 48'd99, 48'd100,
        48'hFFFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
        48'h4000_0000_0000, 48'hFFFF_FE00_0001, 48'hFFFF_FE00_0000,
        48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'h0000_0100_0000,
        48'h0000_0000_FFFF, 48'hFFFF_FE00_0002, 48'h0
    };

    newton_square_root #(
        .RADICAND_BITS(RADICAND_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .radicand(radicand),
        .done(done),
        .root(root)
    );

    newton_square_root_checker #(
        .RADICAND_BITS(RADICAND_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .radicand(radicand),
        .done(done),
        .root(root),
        .outstanding(outstanding),
        .fail_count(fail_count)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    function automatic logic [RADICAND_BITS-1:0] wide_random();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[RADICAND_BITS-1:0];
    endfunction

    function automatic logic [RADICAND_BITS-1:0] pick_radicand();
        logic [RADICAND_BITS-1:0] v;
        logic [23:0]              k;
        int                       sh;
        case ($urandom_range(0, 3))
            0: v = wide_random();
            1: v = wide_random() >> $urandom_range(0, RADICAND_BITS - 1);
            2:
            begin
                k = 24'($urandom) >> $urandom_range(0, 23);
                v = RADICAND_BITS'(k) * RADICAND_BITS'(k);
                v = v + RADICAND_BITS'($urandom_range(0, 2)) - 1;
            end
            default:
            begin
                sh = $urandom_range(0, RADICAND_BITS - 1);
                case ($urandom_range(0, 2))
                    0: v = RADICAND_BITS'(1) << sh;
                    1: v = (RADICAND_BITS'(1) << sh) - 1;
                    default: v = RADICAND_BITS'($urandom_range(0, 1000));
                endcase
            end
        endcase
        return v;
    endfunction

    // one request beat; start stays high across back-to-back beats
    task automatic send_radicand(input logic [RADICAND_BITS-1:0] value, input int gap,
                                 input bit after_idle);
        if (after_idle || gap > 0)
        begin
            start    <= 1'b0;
            radicand <= wide_random();
            if (after_idle)
            begin
                @(posedge clk);
                while (busy)
                    @(posedge clk);
            end
            repeat (gap)
                @(posedge clk);
        end
        start    <= 1'b1;
        radicand <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        bit quiet;
        rst_n    = 1'b0;
        start    = 1'b0;
        radicand = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_radicand(directed[i], $urandom_range(0, 7), $urandom_range(0, 3) == 0);

        quiet = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (quiet)
                send_radicand(pick_radicand(), 0, 1'b0);
            else
                send_radicand(pick_radicand(), $urandom_range(0, 7),
                              $urandom_range(0, 3) == 0);
        end
        start <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
